[design/ray_triangle_intersect_macros.svh]
// ----------------------------------------------------------------------------
// Ray/triangle intersection assertion macros
// Concurrent assertion helpers used by the ray/triangle intersection design.
// ----------------------------------------------------------------------------
`ifndef RAY_TRIANGLE_INTERSECT_MACROS_SVH
`define RAY_TRIANGLE_INTERSECT_MACROS_SVH
`ifndef ASSERT_OFF
`define RTI_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define RTI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define RTI_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define RTI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

[design/rti_pkg.sv]
// ----------------------------------------------------------------------------
// Ray/triangle intersection package
// Widths, register indexes and request/response types.
// ----------------------------------------------------------------------------
package rti_pkg;

  localparam int CoordW   = 32;
  localparam int FracBits = 16;
  localparam int DistW    = 31;
  localparam int ThrW     = 32;
  localparam int CfgW     = 32;
  localparam int CfgIdxW  = 3;

  // Exact widths of the intermediate values.
  localparam int EdgeW  = CoordW + 1;
  localparam int PairW  = 2 * EdgeW;
  localparam int CrossW = PairW + 1;
  localparam int LoW    = (CrossW + 1) / 2;
  localparam int HiW    = CrossW - LoW;
  localparam int MloW   = EdgeW + LoW + 1;
  localparam int MhiW   = EdgeW + HiW;
  localparam int ProdW  = EdgeW + CrossW;
  localparam int DotW   = ProdW + 2;
  localparam int RemW   = DotW + DistW + 1;

  localparam logic [CfgIdxW-1:0] RegOriginX = 3'd0;
  localparam logic [CfgIdxW-1:0] RegOriginY = 3'd1;
  localparam logic [CfgIdxW-1:0] RegOriginZ = 3'd2;
  localparam logic [CfgIdxW-1:0] RegDirX    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegDirY    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegDirZ    = 3'd5;
  localparam logic [CfgIdxW-1:0] RegThresh  = 3'd6;
  localparam logic [CfgIdxW-1:0] RegMinDist = 3'd7;

  localparam logic [CoordW-1:0] DirZReset = CoordW'(1) << FracBits;
  localparam logic [DistW-1:0]  DistMax   = '1;

  typedef struct packed {
    logic signed [CoordW-1:0] a_x;
    logic signed [CoordW-1:0] a_y;
    logic signed [CoordW-1:0] a_z;
    logic signed [CoordW-1:0] b_x;
    logic signed [CoordW-1:0] b_y;
    logic signed [CoordW-1:0] b_z;
    logic signed [CoordW-1:0] c_x;
    logic signed [CoordW-1:0] c_y;
    logic signed [CoordW-1:0] c_z;
  } rti_req_t;

  typedef struct packed {
    logic             hit;
    logic [DistW-1:0] hit_distance;
  } rti_rsp_t;

  typedef struct packed {
    logic            miss;
    logic [DotW-1:0] tn;
    logic [DotW-1:0] den;
  } rti_div_req_t;

  typedef struct packed {
    logic             miss;
    logic             ovf;
    logic [DistW-1:0] quo;
  } rti_div_rsp_t;

endpackage

[design/ray_triangle_intersect.sv]
// ----------------------------------------------------------------------------
// Ray/triangle intersection
// Double-sided exact fixed-point Moller-Trumbore test of one ray against a
// stream of triangles.
// ----------------------------------------------------------------------------
// The ray (origin, direction, parallel threshold and minimum distance) sits in
// configuration registers that the user must write only while the block is
// idle; the block itself does not enforce this. Each request carries one
// triangle and yields exactly one response with a hit flag and the Q15.16
// distance, saturated at the field maximum and zero on a miss. All products
// and sums are exact. It takes one triangle per cycle unless stalled, through
// eight stages of edge, cross-product, dot-product and hit-test arithmetic
// (the wide dot products split into partial products over two stages), 32
// stages of the restoring divider (an overflow check, then one quotient bit
// per stage) and the output register. Stalls back up through the valid chain
// and empty stages are filled, so a waiting response does not block new requests while the pipeline has room.
// ----------------------------------------------------------------------------
`include "ray_triangle_intersect_macros.svh"

module ray_triangle_intersect
  import rti_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  logic               req_valid_i,
  output logic               req_stall_o,
  input  rti_req_t           req_i,
  output logic               rsp_valid_o,
  input  logic               rsp_stall_i,
  output rti_rsp_t           rsp_o
);

  localparam int NGeo = 8;
  localparam int NextIdx [3] = '{1, 2, 0};
  localparam int PrevIdx [3] = '{2, 0, 1};

  // Configuration registers.
  logic signed [CoordW-1:0] org_q [3];
  logic signed [CoordW-1:0] dir_q [3];
  logic [ThrW-1:0]          thr_q;
  logic [DistW-1:0]         mind_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_q[0] <= '0;
      org_q[1] <= '0;
      org_q[2] <= '0;
      dir_q[0] <= '0;
      dir_q[1] <= '0;
      dir_q[2] <= DirZReset;
      thr_q    <= ThrW'(1);
      mind_q   <= DistW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegOriginX: org_q[0] <= cfg_data_i[CoordW-1:0];
        RegOriginY: org_q[1] <= cfg_data_i[CoordW-1:0];
        RegOriginZ: org_q[2] <= cfg_data_i[CoordW-1:0];
        RegDirX:    dir_q[0] <= cfg_data_i[CoordW-1:0];
        RegDirY:    dir_q[1] <= cfg_data_i[CoordW-1:0];
        RegDirZ:    dir_q[2] <= cfg_data_i[CoordW-1:0];
        RegThresh:  thr_q    <= cfg_data_i[ThrW-1:0];
        RegMinDist: mind_q   <= cfg_data_i[DistW-1:0];
      endcase
    end
  end

  // Pipeline control: a stage moves when it is empty or the next one moves.
  logic [NGeo-1:0] geo_vld_q;
  logic [NGeo-1:0] geo_adv;
  logic            div_ready;

  always_comb begin
    geo_adv[NGeo-1] = !geo_vld_q[NGeo-1] || div_ready;
    for (int k = NGeo - 2; k >= 0; k--) begin
      geo_adv[k] = !geo_vld_q[k] || geo_adv[k+1];
    end
  end

  assign req_stall_o = !geo_adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      geo_vld_q <= '0;
    end else begin
      if (geo_adv[0]) begin
        geo_vld_q[0] <= req_valid_i;
      end
      for (int k = 1; k < NGeo; k++) begin
        if (geo_adv[k]) begin
          geo_vld_q[k] <= geo_vld_q[k-1];
        end
      end
    end
  end

  // Direction widened to edge width for the multipliers of stages 2 and 4.
  logic signed [EdgeW-1:0] dir_e [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dir_e[i] = {dir_q[i][CoordW-1], dir_q[i]};
    end
  end

  // Stage 1: edges e1 = b - a, e2 = c - a and s = origin - a.
  logic signed [CoordW-1:0] va [3];
  logic signed [CoordW-1:0] vb [3];
  logic signed [CoordW-1:0] vc [3];
  logic signed [EdgeW-1:0]  e1_d [3];
  logic signed [EdgeW-1:0]  e2_d [3];
  logic signed [EdgeW-1:0]  s_d  [3];
  logic signed [EdgeW-1:0]  e1_1_q [3];
  logic signed [EdgeW-1:0]  e2_1_q [3];
  logic signed [EdgeW-1:0]  s_1_q  [3];

  always_comb begin
    va[0] = req_i.a_x; va[1] = req_i.a_y; va[2] = req_i.a_z;
    vb[0] = req_i.b_x; vb[1] = req_i.b_y; vb[2] = req_i.b_z;
    vc[0] = req_i.c_x; vc[1] = req_i.c_y; vc[2] = req_i.c_z;
    for (int i = 0; i < 3; i++) begin
      e1_d[i] = {vb[i][CoordW-1], vb[i]} - {va[i][CoordW-1], va[i]};
      e2_d[i] = {vc[i][CoordW-1], vc[i]} - {va[i][CoordW-1], va[i]};
      s_d[i]  = {org_q[i][CoordW-1], org_q[i]} - {va[i][CoordW-1], va[i]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (geo_adv[0]) begin
      e1_1_q <= e1_d;
      e2_1_q <= e2_d;
      s_1_q  <= s_d;
    end
  end

  // Stage 2: the cross-product terms of p = dir x e2 and q = s x e1.
  logic signed [PairW-1:0] pm_d [3];
  logic signed [PairW-1:0] pn_d [3];
  logic signed [PairW-1:0] qm_d [3];
  logic signed [PairW-1:0] qn_d [3];
  logic signed [PairW-1:0] pm_q [3];
  logic signed [PairW-1:0] pn_q [3];
  logic signed [PairW-1:0] qm_q [3];
  logic signed [PairW-1:0] qn_q [3];
  logic signed [EdgeW-1:0] e1_2_q [3];
  logic signed [EdgeW-1:0] e2_2_q [3];
  logic signed [EdgeW-1:0] s_2_q  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pm_d[i] = dir_e[NextIdx[i]] * e2_1_q[PrevIdx[i]];
      pn_d[i] = dir_e[PrevIdx[i]] * e2_1_q[NextIdx[i]];
      qm_d[i] = s_1_q[NextIdx[i]] * e1_1_q[PrevIdx[i]];
      qn_d[i] = s_1_q[PrevIdx[i]] * e1_1_q[NextIdx[i]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (geo_adv[1]) begin
      pm_q   <= pm_d;
      pn_q   <= pn_d;
      qm_q   <= qm_d;
      qn_q   <= qn_d;
      e1_2_q <= e1_1_q;
      e2_2_q <= e2_1_q;
      s_2_q  <= s_1_q;
    end
  end

  // Stage 3: finish the cross products.
  logic signed [CrossW-1:0] p_q [3];
  logic signed [CrossW-1:0] q_q [3];
  logic signed [EdgeW-1:0]  e1_3_q [3];
  logic signed [EdgeW-1:0]  e2_3_q [3];
  logic signed [EdgeW-1:0]  s_3_q  [3];

  always_ff @(posedge clk_i) begin
    if (geo_adv[2]) begin
      for (int i = 0; i < 3; i++) begin
        p_q[i] <= CrossW'(pm_q[i]) - CrossW'(pn_q[i]);
        q_q[i] <= CrossW'(qm_q[i]) - CrossW'(qn_q[i]);
      end
      e1_3_q <= e1_2_q;
      e2_3_q <= e2_2_q;
      s_3_q  <= s_2_q;
    end
  end

  // Stage 4: partial products of the four dot products det = e1.p, u = s.p,
  // v = dir.q and t = e2.q, with the wide operand split in a low and high half.
  logic signed [EdgeW-1:0]  opa [4][3];
  logic signed [CrossW-1:0] opb [4][3];
  logic signed [MloW-1:0]   mlo_d [4][3];
  logic signed [MhiW-1:0]   mhi_d [4][3];
  logic signed [MloW-1:0]   mlo_q [4][3];
  logic signed [MhiW-1:0]   mhi_q [4][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      opa[0][i] = e1_3_q[i]; opb[0][i] = p_q[i];
      opa[1][i] = s_3_q[i];  opb[1][i] = p_q[i];
      opa[2][i] = dir_e[i];  opb[2][i] = q_q[i];
      opa[3][i] = e2_3_q[i]; opb[3][i] = q_q[i];
    end
    for (int d = 0; d < 4; d++) begin
      for (int i = 0; i < 3; i++) begin
        mlo_d[d][i] = opa[d][i] * signed'({1'b0, opb[d][i][LoW-1:0]});
        mhi_d[d][i] = opa[d][i] * signed'(opb[d][i][CrossW-1:LoW]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (geo_adv[3]) begin
      mlo_q <= mlo_d;
      mhi_q <= mhi_d;
    end
  end

  // Stage 5: merge the halves into full products.
  logic signed [ProdW-1:0] prod_q [4][3];

  always_ff @(posedge clk_i) begin
    if (geo_adv[4]) begin
      for (int d = 0; d < 4; d++) begin
        for (int i = 0; i < 3; i++) begin
          prod_q[d][i] <= (ProdW'(mhi_q[d][i]) <<< LoW) + ProdW'(mlo_q[d][i]);
        end
      end
    end
  end

  // Stage 6: sum the three products of each dot.
  logic signed [DotW-1:0] dot_q [4];

  always_ff @(posedge clk_i) begin
    if (geo_adv[5]) begin
      for (int d = 0; d < 4; d++) begin
        dot_q[d] <= DotW'(prod_q[d][0]) + DotW'(prod_q[d][1]) + DotW'(prod_q[d][2]);
      end
    end
  end

  // Stage 7: fold the sign of det into all four values and test for a ray
  // parallel to the plane; a zero determinant always misses.
  logic signed [DotW-1:0] nrm_d [4];
  logic signed [DotW-1:0] nrm_q [4];
  logic                   par_miss;
  logic                   par_miss_q;

  always_comb begin
    for (int d = 0; d < 4; d++) begin
      nrm_d[d] = dot_q[0][DotW-1] ? -dot_q[d] : dot_q[d];
    end
    par_miss = (dot_q[0] == '0) || (unsigned'(nrm_d[0]) < DotW'(thr_q));
  end

  always_ff @(posedge clk_i) begin
    if (geo_adv[6]) begin
      nrm_q      <= nrm_d;
      par_miss_q <= par_miss;
    end
  end

  // Stage 8: barycentric range and sign of t; all three triangle edges count as
  // inside.
  logic signed [DotW:0] uv_sum;
  rti_div_req_t         div_req_d;
  rti_div_req_t         div_req_q;

  always_comb begin
    uv_sum         = (DotW+1)'(nrm_q[1]) + (DotW+1)'(nrm_q[2]);
    div_req_d.miss = par_miss_q || nrm_q[1][DotW-1] || nrm_q[2][DotW-1]
                     || nrm_q[3][DotW-1] || (uv_sum > (DotW+1)'(nrm_q[0]));
    div_req_d.tn   = nrm_q[3];
    div_req_d.den  = nrm_q[0];
  end

  always_ff @(posedge clk_i) begin
    if (geo_adv[7]) begin
      div_req_q <= div_req_d;
    end
  end

  // Distance quotient t = (tn << FracBits) / det.
  logic         div_valid;
  logic         out_adv;
  rti_div_rsp_t div_rsp;

  rti_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (geo_vld_q[NGeo-1]),
    .in_ready_o  (div_ready),
    .in_i        (div_req_q),
    .out_valid_o (div_valid),
    .out_ready_i (out_adv),
    .out_o       (div_rsp)
  );

  // Output register: minimum distance test and saturation. A quotient that
  // overflows the field is a hit at the maximum distance.
  logic     rsp_vld_q;
  rti_rsp_t rsp_d;
  rti_rsp_t rsp_q;

  assign out_adv = !rsp_vld_q || !rsp_stall_i;

  always_comb begin
    rsp_d.hit          = !div_rsp.miss && (div_rsp.ovf || (div_rsp.quo > mind_q));
    rsp_d.hit_distance = !rsp_d.hit ? '0 : (div_rsp.ovf ? DistMax : div_rsp.quo);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_vld_q <= 1'b0;
    end else if (out_adv) begin
      rsp_vld_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_valid_o = rsp_vld_q;
  assign rsp_o       = rsp_q;

  `RTI_ASSERT_IMPLY(a_miss_zero, clk_i, rst_ni, rsp_valid_o && !rsp_o.hit, rsp_o.hit_distance == '0, "miss with nonzero distance")
  `RTI_ASSERT_IMPLY(a_hit_beyond_min, clk_i, rst_ni, rsp_valid_o && rsp_o.hit, (rsp_o.hit_distance > mind_q) || (rsp_o.hit_distance == DistMax), "hit not beyond minimum distance")
  `RTI_ASSERT_IMPLY(a_stall_full, clk_i, rst_ni, req_stall_o, geo_vld_q[0], "stall with empty first stage")
  `RTI_ASSERT_NEXT(a_hold_item, clk_i, rst_ni, geo_vld_q[NGeo-1] && !div_ready, geo_vld_q[NGeo-1], "blocked request lost")

endmodule

[design/rti_div.sv]
// ----------------------------------------------------------------------------
// Ray/triangle distance divider
// Pipelined restoring divider, an overflow-check entry stage, then one quotient bit per stage.
// ----------------------------------------------------------------------------
module rti_div
  import rti_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  rti_div_req_t in_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output rti_div_rsp_t out_o
);

  localparam int NSt = DistW + 1;

  logic [NSt-1:0]   vld_q;
  logic [NSt-1:0]   adv;
  logic [RemW-1:0]  rem_q [NSt];
  logic [DotW-1:0]  den_q [NSt];
  logic [DistW-1:0] quo_q [NSt];
  logic [NSt-1:0]   miss_q;
  logic [NSt-1:0]   ovf_q;
  logic [RemW-1:0]  num;

  always_comb begin
    adv[NSt-1] = !vld_q[NSt-1] || out_ready_i;
    for (int k = NSt - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign in_ready_o = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NSt; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // Numerator is tn scaled by the fraction bits; a quotient that does not fit
  // the distance field is flagged here and saturated downstream.
  assign num = RemW'(in_i.tn) << FracBits;

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      rem_q[0]  <= num;
      den_q[0]  <= in_i.den;
      quo_q[0]  <= '0;
      miss_q[0] <= in_i.miss;
      ovf_q[0]  <= num >= (RemW'(in_i.den) << DistW);
    end
  end

  for (genvar s = 1; s < NSt; s++) begin : g_step
    localparam int Bit = DistW - s;
    logic [RemW-1:0] trial;
    logic            take;

    assign trial = RemW'(den_q[s-1]) << Bit;
    assign take  = rem_q[s-1] >= trial;

    always_ff @(posedge clk_i) begin
      if (adv[s]) begin
        rem_q[s]  <= take ? rem_q[s-1] - trial : rem_q[s-1];
        den_q[s]  <= den_q[s-1];
        quo_q[s]  <= quo_q[s-1] | (DistW'(take) << Bit);
        miss_q[s] <= miss_q[s-1];
        ovf_q[s]  <= ovf_q[s-1];
      end
    end
  end

  assign out_valid_o = vld_q[NSt-1];
  assign out_o.miss  = miss_q[NSt-1];
  assign out_o.ovf   = ovf_q[NSt-1];
  assign out_o.quo   = quo_q[NSt-1];

endmodule
